// ----- hw/rtl/sntp_pkg.sv -----
// ----------------------------------------------------------------------------
// sntp_pkg
// Shared types, codes and timestamp conversions for the SNTP client
// sequencer and its port checker.
// ----------------------------------------------------------------------------
package sntp_pkg;

  // Fraction bits of the real-time clock count.
  localparam int CLOCK_FRACTION_BITS = 10;
  // Year that splits NTP era 0 from era 1 when a server time is decoded.
  localparam int PIVOT_YEAR = 2016;

  // Shift from clock ticks to 32.28 fixed point.
  localparam int CLK_SHIFT = 28 - CLOCK_FRACTION_BITS;

  // Seconds from 1900 to 1970.
  localparam logic [63:0] NTP_UNIX_DIFF = 64'd2208988800;
  localparam logic [63:0] NTP_BASE_28   = NTP_UNIX_DIFF << 28;
  // Seconds from 1900 to the pivot year (365-day years).
  localparam logic [63:0] PIVOT_SECS    = 64'(PIVOT_YEAR - 1900) * 64'd31536000;

  // Configuration register indexes.
  localparam logic [2:0] REG_SERVER_ADDRESS = 3'd0;
  localparam logic [2:0] REG_INITIAL_IVL    = 3'd1;
  localparam logic [2:0] REG_NORMAL_IVL     = 3'd2;
  localparam logic [2:0] REG_RETRY_IVL      = 3'd3;
  localparam logic [2:0] REG_CLOCK_OFFSET   = 3'd4;
  localparam logic [2:0] REG_MAX_DELAY      = 3'd5;

  // Command completion reports from the link engine.
  localparam logic [1:0] RPT_NONE    = 2'd0;
  localparam logic [1:0] RPT_SUCCESS = 2'd1;

  // NTP header values checked on a reply.
  localparam logic [1:0] LEAP_ALARM  = 2'd3;
  localparam logic [2:0] MODE_SERVER = 3'd4;

  typedef enum logic [2:0] {
    PH_DISC      = 3'd0,
    PH_CONNECT   = 3'd1,
    PH_CONNECTED = 3'd2,
    PH_SEND      = 3'd3,
    PH_CLOSE     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_OK   = 2'd1,
    RES_FAIL = 2'd2
  } result_t;

  typedef enum logic [1:0] {
    KIND_INITIAL = 2'd0,
    KIND_NORMAL  = 2'd1,
    KIND_RETRY   = 2'd2
  } ivl_kind_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_SEND  = 2'd2,
    CMD_CLOSE = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_LEAP     = 3'd2,
    ST_VERSION  = 3'd3,
    ST_MODE     = 3'd4,
    ST_KISS     = 3'd5,
    ST_DELAY    = 3'd6
  } status_t;

  // Clock count to 32.32 NTP timestamp.
  function automatic logic [63:0] ntp_from_clock(input logic [63:0] clk_cnt);
    logic [63:0] t;
    t = NTP_BASE_28 + (clk_cnt << CLK_SHIFT);
    return t << 4;
  endfunction

  // 32.32 NTP timestamp to clock count, with the era chosen by the pivot.
  function automatic logic [63:0] clock_from_ntp(input logic [63:0] ntp);
    logic [59:0] t60;
    logic        era;
    logic [63:0] t;
    t60 = ntp[63:4];
    era = (64'(t60[59:28]) > PIVOT_SECS) ? 1'b0 : 1'b1;
    t   = {3'b000, era, t60};
    t   = t - NTP_BASE_28;
    return t >> CLK_SHIFT;
  endfunction

endpackage

// ----- hw/rtl/sntp_client_sequencer.sv -----
// ----------------------------------------------------------------------------
// sntp_client_sequencer
// One poll of a simple network time client per input beat: link sequencing,
// request time stamping and reply checking with clock load.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid/in_stall) carries one poll beat: link status,
//   command report, reconnect request, the current clock and a reply, if any.
// - Result channel (out_valid/out_stall) returns exactly one beat per poll:
//   the link command, the request transmit stamp, a clock load and the reply
//   status.
// - Configuration channel (cfg_valid/cfg_ready) is always ready; write only
//   while no poll is in flight.
// - The poll is held in an input register, evaluated by one pass of logic
//   and captured in the result register. One beat per cycle is sustained
//   while the receiver does not stall.
// - When the receiver stalls, the result register holds; the input register
//   still takes a beat if empty, then in_stall rises until the result drains.
// - Synchronous reset empties both registers, sets the sequencer to
//   disconnected with the initial interval and loads register defaults.
// ----------------------------------------------------------------------------
module sntp_client_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // Poll input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_link_busy,
  input  logic        in_link_up,
  input  logic [1:0]  in_cmd_report,
  input  logic        in_reconnect_req,
  input  logic [63:0] in_clock_now,
  input  logic        in_reply_arrived,
  input  logic [1:0]  in_reply_leap,
  input  logic [2:0]  in_reply_version,
  input  logic [2:0]  in_reply_mode,
  input  logic [7:0]  in_reply_stratum,
  input  logic [63:0] in_reply_originate,
  input  logic [63:0] in_reply_receive,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_command,
  output logic [63:0] out_transmit_stamp,
  output logic        out_clock_write,
  output logic [63:0] out_clock_value,
  output logic [2:0]  out_reply_status
);

  // Configuration registers.
  logic [31:0]        server_address_r;
  logic [23:0]        initial_ivl_r;
  logic [23:0]        normal_ivl_r;
  logic [23:0]        retry_ivl_r;
  logic signed [9:0]  clock_offset_r;
  logic [15:0]        max_delay_r;

  // Input register.
  logic        in_vld_r;
  logic        busy_r;
  logic        up_r;
  logic [1:0]  report_r;
  logic        recon_req_r;
  logic [63:0] now_r;
  logic [63:0] now_ntp_r;
  logic        arrived_r;
  logic [1:0]  leap_r;
  logic [2:0]  version_r;
  logic [2:0]  mode_r;
  logic [7:0]  stratum_r;
  logic [63:0] originate_r;
  logic [63:0] receive_adj_r;

  // Sequencer state.
  sntp_pkg::phase_t    phase_r, phase_nxt;
  sntp_pkg::result_t   pend_r, pend_nxt;
  logic                recon_r, recon_nxt;
  logic [63:0]         ivl_start_r, ivl_start_nxt;
  sntp_pkg::ivl_kind_t ivl_kind_r, ivl_kind_nxt;

  // Result register.
  logic                out_vld_r;
  sntp_pkg::command_t  cmd_r, cmd_nxt;
  logic [63:0]         tx_r, tx_nxt;
  logic                cw_r, cw_nxt;
  logic [63:0]         cval_r, cval_nxt;
  sntp_pkg::status_t   status_r, status_nxt;

  logic                advance;
  logic                fire;
  sntp_pkg::result_t   pend_lat;
  logic                recon_lat;
  logic [23:0]         ivl_secs;
  logic                ivl_done;
  logic [63:0]         delay;
  logic [63:0]         cval_calc;
  logic                reply_ok;

  // Handshake: the result register frees when empty or taken.
  assign advance   = !out_vld_r || !out_stall;
  assign fire      = in_vld_r && advance;
  assign in_stall  = in_vld_r && !advance;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_address_r <= '0;
      initial_ivl_r    <= 24'd1;
      normal_ivl_r     <= 24'd600;
      retry_ivl_r      <= 24'd60;
      clock_offset_r   <= '0;
      max_delay_r      <= 16'd50;
    end else if (cfg_valid) begin
      case (cfg_index)
        sntp_pkg::REG_SERVER_ADDRESS: server_address_r <= cfg_wdata;
        sntp_pkg::REG_INITIAL_IVL:    initial_ivl_r    <= cfg_wdata[23:0];
        sntp_pkg::REG_NORMAL_IVL:     normal_ivl_r     <= cfg_wdata[23:0];
        sntp_pkg::REG_RETRY_IVL:      retry_ivl_r      <= cfg_wdata[23:0];
        sntp_pkg::REG_CLOCK_OFFSET:   clock_offset_r   <= $signed(cfg_wdata[9:0]);
        sntp_pkg::REG_MAX_DELAY:      max_delay_r      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Input register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  // Input register payload, with the transmit stamp and the offset
  // receive time worked out on the way in.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      busy_r        <= in_link_busy;
      up_r          <= in_link_up;
      report_r      <= in_cmd_report;
      recon_req_r   <= in_reconnect_req;
      now_r         <= in_clock_now;
      now_ntp_r     <= sntp_pkg::ntp_from_clock(in_clock_now);
      arrived_r     <= in_reply_arrived;
      leap_r        <= in_reply_leap;
      version_r     <= in_reply_version;
      mode_r        <= in_reply_mode;
      stratum_r     <= in_reply_stratum;
      originate_r   <= in_reply_originate;
      receive_adj_r <= in_reply_receive + (64'(clock_offset_r) << 22);
    end
  end

  // Latch the command report and the reconnect request.
  always_comb begin
    if (report_r == sntp_pkg::RPT_SUCCESS) begin
      pend_lat = sntp_pkg::RES_OK;
    end else if (report_r != sntp_pkg::RPT_NONE) begin
      pend_lat = sntp_pkg::RES_FAIL;
    end else begin
      pend_lat = pend_r;
    end
    recon_lat = recon_r || recon_req_r;
  end

  // Interval timer compare; elapsed time wraps modulo 2^64.
  always_comb begin
    unique case (ivl_kind_r)
      sntp_pkg::KIND_INITIAL: ivl_secs = initial_ivl_r;
      sntp_pkg::KIND_NORMAL:  ivl_secs = normal_ivl_r;
      default:                ivl_secs = retry_ivl_r;
    endcase
    ivl_done = (now_r - ivl_start_r) >= (64'(ivl_secs) << sntp_pkg::CLOCK_FRACTION_BITS);
  end

  // Reply arithmetic.
  assign delay     = now_ntp_r - originate_r;
  assign cval_calc = sntp_pkg::clock_from_ntp(receive_adj_r);

  // Output logic: command, transmit stamp and reply check.
  always_comb begin
    cmd_nxt    = sntp_pkg::CMD_NONE;
    tx_nxt     = '0;
    cw_nxt     = 1'b0;
    cval_nxt   = '0;
    status_nxt = sntp_pkg::ST_NONE;
    if (!busy_r && up_r) begin
      unique case (phase_r)
        sntp_pkg::PH_CONNECT: begin
          if (pend_lat == sntp_pkg::RES_NONE) cmd_nxt = sntp_pkg::CMD_OPEN;
        end
        sntp_pkg::PH_SEND: begin
          if (pend_lat == sntp_pkg::RES_NONE) begin
            cmd_nxt = sntp_pkg::CMD_SEND;
            tx_nxt  = now_ntp_r;
          end
        end
        sntp_pkg::PH_CLOSE: begin
          if (pend_lat == sntp_pkg::RES_NONE) cmd_nxt = sntp_pkg::CMD_CLOSE;
        end
        default: ;
      endcase
    end
    if (arrived_r) begin
      priority if (leap_r == sntp_pkg::LEAP_ALARM) begin
        status_nxt = sntp_pkg::ST_LEAP;
      end else if (version_r == 3'd0) begin
        status_nxt = sntp_pkg::ST_VERSION;
      end else if (mode_r != sntp_pkg::MODE_SERVER) begin
        status_nxt = sntp_pkg::ST_MODE;
      end else if (stratum_r == 8'd0) begin
        status_nxt = sntp_pkg::ST_KISS;
      end else if (delay[63:22] > 42'(max_delay_r)) begin
        status_nxt = sntp_pkg::ST_DELAY;
      end else begin
        status_nxt = sntp_pkg::ST_ACCEPTED;
        cw_nxt     = 1'b1;
        cval_nxt   = cval_calc;
      end
    end
  end

  assign reply_ok = (status_nxt == sntp_pkg::ST_ACCEPTED);

  // Next-state logic of the link sequencer and the interval timer.
  always_comb begin
    phase_nxt     = phase_r;
    pend_nxt      = pend_lat;
    recon_nxt     = recon_lat;
    ivl_start_nxt = ivl_start_r;
    ivl_kind_nxt  = ivl_kind_r;
    if (!busy_r) begin
      if (!up_r) begin
        phase_nxt     = sntp_pkg::PH_DISC;
        pend_nxt      = sntp_pkg::RES_NONE;
        ivl_start_nxt = now_r;
        ivl_kind_nxt  = sntp_pkg::KIND_INITIAL;
      end else begin
        unique case (phase_r)
          sntp_pkg::PH_CONNECT: begin
            if (pend_lat == sntp_pkg::RES_OK) begin
              phase_nxt = sntp_pkg::PH_CONNECTED;
              pend_nxt  = sntp_pkg::RES_NONE;
            end else if (pend_lat != sntp_pkg::RES_NONE) begin
              phase_nxt     = sntp_pkg::PH_CLOSE;
              pend_nxt      = sntp_pkg::RES_NONE;
              ivl_start_nxt = now_r;
              ivl_kind_nxt  = sntp_pkg::KIND_RETRY;
            end
          end
          sntp_pkg::PH_CONNECTED: begin
            if (recon_lat) begin
              phase_nxt = sntp_pkg::PH_CLOSE;
            end else if (ivl_done) begin
              phase_nxt = sntp_pkg::PH_SEND;
            end
          end
          sntp_pkg::PH_SEND: begin
            if (pend_lat != sntp_pkg::RES_NONE) begin
              phase_nxt     = sntp_pkg::PH_CONNECTED;
              pend_nxt      = sntp_pkg::RES_NONE;
              ivl_start_nxt = now_r;
              ivl_kind_nxt  = sntp_pkg::KIND_RETRY;
            end
          end
          sntp_pkg::PH_CLOSE: begin
            if (pend_lat != sntp_pkg::RES_NONE) begin
              phase_nxt = sntp_pkg::PH_DISC;
              pend_nxt  = sntp_pkg::RES_NONE;
            end
          end
          default: begin
            recon_nxt = 1'b0;
            if (ivl_done && (server_address_r != 32'd0)) begin
              phase_nxt = sntp_pkg::PH_CONNECT;
            end else begin
              phase_nxt = sntp_pkg::PH_DISC;
            end
          end
        endcase
      end
    end
    // An accepted reply restarts the normal interval from the new clock.
    if (reply_ok) begin
      ivl_start_nxt = cval_calc;
      ivl_kind_nxt  = sntp_pkg::KIND_NORMAL;
    end
  end

  // Sequencer state commits as each poll moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sntp_pkg::PH_DISC;
      pend_r      <= sntp_pkg::RES_NONE;
      recon_r     <= 1'b0;
      ivl_start_r <= '0;
      ivl_kind_r  <= sntp_pkg::KIND_INITIAL;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      recon_r     <= recon_nxt;
      ivl_start_r <= ivl_start_nxt;
      ivl_kind_r  <= ivl_kind_nxt;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      cmd_r    <= cmd_nxt;
      tx_r     <= tx_nxt;
      cw_r     <= cw_nxt;
      cval_r   <= cval_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_command        = cmd_r;
  assign out_transmit_stamp = tx_r;
  assign out_clock_write    = cw_r;
  assign out_clock_value    = cval_r;
  assign out_reply_status   = status_r;

endmodule

// ----- hw/rtl/sntp_checker.sv -----
// ----------------------------------------------------------------------------
// sntp_checker
// Port-level checks on the SNTP client sequencer, bound into the sequencer module.
// ----------------------------------------------------------------------------
module sntp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_command,
  input logic [63:0] out_transmit_stamp,
  input logic        out_clock_write,
  input logic [63:0] out_clock_value,
  input logic [2:0]  out_reply_status
);

  // A transmit stamp only goes out with a send command.
  a_tx_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command != sntp_pkg::CMD_SEND) |-> (out_transmit_stamp == 64'd0))
    else $error("transmit stamp without send command");

  // A clock load goes with an accepted reply and nothing else.
  a_write_iff_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_clock_write == (out_reply_status == sntp_pkg::ST_ACCEPTED)))
    else $error("clock load and reply status disagree");

  // Without a clock load the load value is zero.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_clock_write |-> (out_clock_value == 64'd0))
    else $error("clock value set without clock load");

  // Nothing comes out the cycle after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_command)
      && $stable(out_clock_value) && $stable(out_reply_status))
    else $error("stalled result beat changed");

endmodule

bind sntp_client_sequencer sntp_checker u_sntp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_command        (out_command),
  .out_transmit_stamp (out_transmit_stamp),
  .out_clock_write    (out_clock_write),
  .out_clock_value    (out_clock_value),
  .out_reply_status   (out_reply_status)
);
